// ===== src/mtrd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtrd_pkg
// shared constants, types and the tempering function of the ranged draw
// ----------------------------------------------------------------------------
`default_nettype none

package mtrd_pkg;

  localparam int unsigned StateWords   = 624;
  localparam int unsigned TwistOffset  = 397;
  localparam int unsigned IdxW         = 10;
  localparam logic [31:0] DefaultSeed  = 32'd4357;
  localparam logic [31:0] SeedMult     = 32'd69069;
  localparam logic [31:0] MatrixA      = 32'h9908b0df;
  localparam logic [31:0] ResetSeed    = 32'd1;

  localparam logic CmdDraw = 1'b0;
  localparam logic CmdSeed = 1'b1;

  // datapath operations, issued by the controller
  typedef enum logic [2:0] {
    OpNone,
    OpSeedInit,   // write word 0, latch seed
    OpSeedStep,   // write next seed word
    OpTwRead,     // issue reads for one twist word
    OpTwWrite,    // write one twisted word
    OpDrawRead,   // read word at index
    OpDivInit,    // temper and start divider
    OpDivStep     // one quotient bit
  } mtrd_op_e;

  typedef struct packed {
    mtrd_op_e    op;
    logic [1:0]  rd_slot;    // which twist source is read now
    logic [IdxW-1:0] addr;
  } mtrd_cmd_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== src/mtrd_datapath.sv =====
// ----------------------------------------------------------------------------
// mtrd_datapath
// word table, seed and twist arithmetic, tempering and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none

module mtrd_datapath
  import mtrd_pkg::*;
#(
  parameter int unsigned STATE_WORDS = StateWords
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mtrd_cmd_t       cmd_i,
  input  wire logic [31:0]     operand_i,
  input  wire logic            use_default_i,
  output logic [31:0]          value_o,
  output logic [31:0]          seed_now_o
);

  logic [31:0] mem_q [STATE_WORDS];
  logic [31:0] rdata_q;
  logic [31:0] prev_q, hi_q, lo_q;
  logic [31:0] seed_q;
  logic [31:0] rem_q, quo_q, div_q;
  logic [31:0] twisted;
  logic [31:0] y;
  logic [32:0] trial;
  logic [1:0]  slot_q;

  assign y = {hi_q[31], lo_q[30:0]};
  assign twisted = rdata_q ^ (y >> 1) ^ (y[0] ? MatrixA : 32'd0);

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpSeedInit: mem_q[cmd_i.addr] <= use_default_i ? DefaultSeed : operand_i;
      OpSeedStep: mem_q[cmd_i.addr] <= prev_q;
      OpTwWrite:  mem_q[cmd_i.addr] <= twisted;
      default: ;
    endcase
    rdata_q <= mem_q[cmd_i.addr];
  end

  assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

  always_ff @(posedge clk_i) begin
    slot_q <= cmd_i.rd_slot;
    // slot_q is registered alongside the read data, so a slot 1/2 read is taken from rdata_q
    if (slot_q == 2'd1) hi_q <= rdata_q;
    if (slot_q == 2'd2) lo_q <= rdata_q;
    unique case (cmd_i.op)
      OpSeedInit: prev_q <= (use_default_i ? DefaultSeed : operand_i) * SeedMult;
      OpSeedStep: prev_q <= prev_q * SeedMult;
      OpDivInit: begin
        quo_q <= temper(rdata_q);
        rem_q <= '0;
        div_q <= operand_i;
      end
      OpDivStep: begin
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], quo_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= ResetSeed;
    end else if (cmd_i.op == OpSeedInit) begin
      seed_q <= use_default_i ? DefaultSeed : operand_i;
    end
  end

  assign value_o    = rem_q;
  assign seed_now_o = seed_q;

endmodule

`default_nettype wire

// ===== src/mtrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtrd_ctrl
// command sequencer: seeding sweep, twist sweep, draw and divide steps
// ----------------------------------------------------------------------------
`default_nettype none

module mtrd_ctrl
  import mtrd_pkg::*;
#(
  parameter int unsigned STATE_WORDS  = StateWords,
  parameter int unsigned TWIST_OFFSET = TwistOffset
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        cmd_i,
  input  wire logic        zero_i,
  output logic             busy_o,
  output logic             done_o,
  output logic             use_default_o,
  output logic             clear_o,
  output mtrd_cmd_t        dp_o
);

  localparam int unsigned IW = $clog2(STATE_WORDS + 2);

  typedef enum logic [3:0] {
    StIdle, StSeedInit, StSeedStep, StTwRdHi, StTwRdLo, StTwRdFar, StTwWait,
    StTwWrite, StDrawRd, StDrawWait, StDivInit, StDivStep, StDone
  } state_e;

  state_e      state_q;
  logic [IW-1:0] idx_q, k_q;
  logic [5:0]  cnt_q;
  logic        dflt_q, drawing_q;
  logic [IW-1:0] nxt_k, far_k;

  assign nxt_k = (k_q == IW'(STATE_WORDS - 1)) ? '0 : k_q + 1'b1;
  assign far_k = (k_q >= IW'(STATE_WORDS - TWIST_OFFSET)) ?
                 IW'(k_q - IW'(STATE_WORDS - TWIST_OFFSET)) : IW'(k_q + IW'(TWIST_OFFSET));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= IW'(STATE_WORDS + 1);
      k_q <= '0; cnt_q <= '0; dflt_q <= 1'b0; drawing_q <= 1'b0;
      done_o <= 1'b0; clear_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      clear_o <= 1'b0;
      unique case (state_q)
        StIdle: if (start_i) begin
          drawing_q <= (cmd_i == CmdDraw);
          dflt_q <= 1'b0;
          if (cmd_i == CmdSeed) begin
            state_q <= StSeedInit;
          end else if (zero_i) begin
            clear_o <= 1'b1; done_o <= 1'b1;
          end else if (idx_q == IW'(STATE_WORDS + 1)) begin
            dflt_q <= 1'b1; state_q <= StSeedInit;
          end else if (idx_q == IW'(STATE_WORDS)) begin
            k_q <= '0; state_q <= StTwRdHi;
          end else begin
            state_q <= StDrawRd;
          end
        end
        StSeedInit: begin k_q <= IW'(1); state_q <= StSeedStep; end
        StSeedStep: begin
          if (k_q == IW'(STATE_WORDS - 1)) begin
            idx_q <= IW'(STATE_WORDS);
            if (drawing_q) begin k_q <= '0; state_q <= StTwRdHi; end
            else begin clear_o <= 1'b1; done_o <= 1'b1; state_q <= StIdle; end
          end else k_q <= k_q + 1'b1;
        end
        StTwRdHi:  state_q <= StTwRdLo;
        StTwRdLo:  state_q <= StTwRdFar;
        StTwRdFar: state_q <= StTwWait;
        StTwWait:  state_q <= StTwWrite;
        StTwWrite: begin
          if (k_q == IW'(STATE_WORDS - 1)) begin
            idx_q <= '0; state_q <= StDrawRd;
          end else begin k_q <= k_q + 1'b1; state_q <= StTwRdHi; end
        end
        StDrawRd:   state_q <= StDrawWait;
        StDrawWait: state_q <= StDivInit;
        StDivInit:  begin cnt_q <= '0; idx_q <= idx_q + 1'b1; state_q <= StDivStep; end
        StDivStep:  begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd31) state_q <= StDone;
        end
        StDone: begin done_o <= 1'b1; state_q <= StIdle; end
        default: state_q <= StIdle;
      endcase
    end
  end

  // word address and operation per state
  always_comb begin
    dp_o = '{op: OpNone, rd_slot: 2'd0, addr: '0};
    unique case (state_q)
      StSeedInit: begin dp_o.op = OpSeedInit; dp_o.addr = '0; end
      StSeedStep: begin dp_o.op = OpSeedStep; dp_o.addr = IdxW'(k_q); end
      StTwRdHi:   begin dp_o.addr = IdxW'(k_q);   dp_o.rd_slot = 2'd1; end
      StTwRdLo:   begin dp_o.addr = IdxW'(nxt_k); dp_o.rd_slot = 2'd2; end
      StTwRdFar:  begin dp_o.addr = IdxW'(far_k); end
      StTwWait:   begin dp_o.addr = IdxW'(far_k); end
      StTwWrite:  begin dp_o.op = OpTwWrite; dp_o.addr = IdxW'(k_q); end
      StDrawRd:   begin dp_o.op = OpDrawRead; dp_o.addr = IdxW'(idx_q); end
      StDrawWait: begin dp_o.addr = IdxW'(idx_q); end
      StDivInit:  dp_o.op = OpDivInit;
      StDivStep:  dp_o.op = OpDivStep;
      default: ;
    endcase
  end

  assign busy_o = (state_q != StIdle);
  assign use_default_o = dflt_q;

endmodule

`default_nettype wire

// ===== src/mt19937_ranged_draw.sv =====
// ----------------------------------------------------------------------------
// mt19937_ranged_draw
// mt19937 generator with seed load and bounded draws
// ----------------------------------------------------------------------------
// usage:
//   a word is accepted when start is high and busy is low; cmd_i selects
//   a draw (0) or a seed load (1), operand_i is the bound or the seed
//   each word gives one result: valid_o is high for exactly one cycle with
//   value_o and seed_now_o; the receiver cannot stall the block
// operation:
//   seed load: one table word written per cycle
//   draw: read, temper, 32-step restoring divider
//   draw that exhausts the table: a twist sweep first, each table word passing
//   the read high, read low, read far, wait and write states over the single read port
//   first draw without a seed: default seeding, twist and draw
//   zero bound: result in the cycle after the word is accepted, state untouched
//   the block takes one word at a time; busy stays high until the result
// reset:
//   seed reads 1, table marked never seeded; the table itself is not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_ranged_draw
  import mtrd_pkg::*;
#(
  parameter int unsigned STATE_WORDS  = StateWords,
  parameter int unsigned TWIST_OFFSET = TwistOffset
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cmd_i,
  input  wire logic [31:0] operand_i,
  output logic             valid_o,
  output logic [31:0]      value_o,
  output logic [31:0]      seed_now_o
);

  mtrd_cmd_t   dp_cmd;
  logic        use_default;
  logic        clear_val;
  logic        done;
  logic        cmd_q;
  logic [31:0] operand_q;
  logic [31:0] dp_value;

  // hold the accepted word for the whole operation
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q     <= cmd_i;
      operand_q <= operand_i;
    end
  end

  mtrd_ctrl #(
    .STATE_WORDS (STATE_WORDS),
    .TWIST_OFFSET(TWIST_OFFSET)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i      (start),
    .cmd_i        (cmd_i),
    .zero_i       (operand_i == 32'd0),
    .busy_o       (busy),
    .done_o       (done),
    .use_default_o(use_default),
    .clear_o      (clear_val),
    .dp_o         (dp_cmd)
  );

  mtrd_datapath #(
    .STATE_WORDS(STATE_WORDS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i        (dp_cmd),
    .operand_i    (operand_q),
    .use_default_i(use_default),
    .value_o      (dp_value),
    .seed_now_o   (seed_now_o)
  );

  // seed loads and zero bounds return zero
  assign valid_o = done;
  assign value_o = clear_val ? 32'd0 : dp_value;

`ifndef SYNTHESIS
  // a result follows only an accepted word
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy) || $past(start))
    else $error("result without a word");
  // a draw result is below its bound
  a_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !clear_val && cmd_q == CmdDraw |-> value_o < operand_q)
    else $error("draw not below bound");
  // a seed load reports the loaded seed
  a_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && cmd_q == CmdSeed && $past(busy) |-> seed_now_o == operand_q)
    else $error("seed not recorded");
`endif

endmodule

`default_nettype wire

// ===== test/mtrd_checker.sv =====
// ----------------------------------------------------------------------------
// mtrd_checker
// watches the command and result channels, predicts each result and compares
// ----------------------------------------------------------------------------
`default_nettype none

module mtrd_checker
  import mtrd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic        cmd_i,
  input  wire logic [31:0] operand_i,
  input  wire logic        valid_o,
  input  wire logic [31:0] value_o,
  input  wire logic [31:0] seed_now_o,
  output int               fail_count,
  output int               pending,
  output int               twist_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NeverSeeded = StateWords + 1;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] seed;
  } draw_word_t;

  logic [31:0] gen_words [StateWords];
  int unsigned gen_pos;
  logic [31:0] gen_seed;
  draw_word_t  words_due [$];

  function automatic logic [31:0] scramble(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    return y ^ (y >> 18);
  endfunction

  function automatic void fill_words(input logic [31:0] s);
    gen_words[0] = s;
    for (int i = 1; i < StateWords; i++) gen_words[i] = gen_words[i-1] * SeedMult;
    gen_pos  = StateWords;
    gen_seed = s;
  endfunction

  function automatic void regenerate();
    logic [31:0] y;
    for (int k = 0; k < StateWords; k++) begin
      y = {gen_words[k][31], gen_words[(k + 1) % StateWords][30:0]};
      gen_words[k] = gen_words[(k + TwistOffset) % StateWords] ^ (y >> 1)
                     ^ (y[0] ? MatrixA : 32'd0);
    end
    gen_pos = 0;
    twist_count++;
  endfunction

  function automatic draw_word_t predict(input logic c, input logic [31:0] op);
    draw_word_t r;
    r.value = '0;
    if (c == CmdSeed) begin
      fill_words(op);
    end else if (op != 0) begin
      if (gen_pos >= StateWords) begin
        if (gen_pos == NeverSeeded) fill_words(DefaultSeed);
        regenerate();
      end
      r.value = scramble(gen_words[gen_pos]) % op;
      gen_pos++;
    end
    r.seed = gen_seed;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    draw_word_t w;
    if (!rst_ni) begin
      gen_pos     = NeverSeeded;
      gen_seed    = ResetSeed;
      words_due.delete();
      fail_count  = 0;
      twist_count = 0;
    end else begin
      if (start && !busy) words_due.push_back(predict(cmd_i, operand_i));
      if (valid_o) begin
        if (words_due.size() == 0) begin
          report("unexpected result", value_o, 32'd0);
        end else begin
          w = words_due.pop_front();
          if (value_o !== w.value) report("value", value_o, w.value);
          if (seed_now_o !== w.seed) report("seed_now", seed_now_o, w.seed);
        end
      end
    end
    pending = words_due.size();
  end

endmodule

`default_nettype wire

// ===== test/mt19937_ranged_draw_test.sv =====
// ----------------------------------------------------------------------------
// mt19937_ranged_draw_test
// drives seed loads and bounded draws into the generator, with idle phases;
// the checker beside the block predicts every result and counts mismatches
// ----------------------------------------------------------------------------
`default_nettype none

module mt19937_ranged_draw_test;
  import mtrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 20000000;
  localparam int RandomWords = 1250;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        cmd_i = CmdDraw;
  logic [31:0] operand_i = '0;
  logic        busy, valid_o;
  logic [31:0] value_o, seed_now_o;
  int          fail_count, pending, twist_count;
  int          cycles = 0;
  int          idle_pct = 0;
  int          n_draws = 0, n_seeds = 0, n_zero = 0;

  always #5 clk_i = ~clk_i;

  mt19937_ranged_draw i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .operand_i,
    .valid_o, .value_o, .seed_now_o
  );

  mtrd_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .operand_i,
    .valid_o, .value_o, .seed_now_o, .fail_count, .pending, .twist_count
  );

  // watchdog: the slowest legal run is well below this
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hand one word to the block; start stays high into the next word when no
  // idle cycles are inserted
  task automatic send_word(input logic c, input logic [31:0] op);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start     <= 1'b1;
    cmd_i     <= c;
    operand_i <= op;
    // busy only moves at a rising edge, so its value here holds at the next one
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    if (c == CmdSeed) n_seeds++;
    else if (op == 0) n_zero++;
    else n_draws++;
  endtask

  // bound mix: zero, one, full range, small bounds, powers of two and one below them
  function automatic logic [31:0] pick_bound();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'hffffffff;
      3, 4:    return $urandom_range(100, 1);
      5:       return (32'd1 << $urandom_range(31)) - $urandom_range(1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int phase;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero bound before any seed must not trigger the default seeding
    send_word(CmdDraw, 32'd0);
    // first real draw seeds with the default value, twists and draws
    send_word(CmdDraw, 32'd7);
    send_word(CmdDraw, 32'hffffffff);
    send_word(CmdDraw, 32'd1);
    send_word(CmdDraw, 32'h80000000);
    send_word(CmdDraw, 32'd0);
    // zero seed leaves an all-zero table
    send_word(CmdSeed, 32'd0);
    send_word(CmdDraw, 32'hffffffff);
    send_word(CmdDraw, 32'd3);
    send_word(CmdSeed, 32'hffffffff);
    send_word(CmdDraw, 32'hffffffff);
    send_word(CmdDraw, 32'h7fffffff);
    send_word(CmdSeed, 32'h5a5a5a5a);
    send_word(CmdDraw, 32'h0000ffff);
    send_word(CmdDraw, 32'd0);
    send_word(CmdDraw, 32'd2);

    // sender pauses until the block has drained everything
    @(negedge clk_i);
    start <= 1'b0;
    wait (pending == 0);

    // random part in four idling phases; seeds are rare so that long draw
    // runs exhaust the table and force twists
    for (int i = 0; i < RandomWords; i++) begin
      phase = i * 4 / RandomWords;
      case (phase)
        0:       idle_pct = 0;
        1:       idle_pct = 62;
        2:       idle_pct = 0;
        default: idle_pct = 32;
      endcase
      if ($urandom_range(199) == 0) send_word(CmdSeed, $urandom);
      else send_word(CmdDraw, pick_bound());
    end
    @(negedge clk_i);
    start <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk_i);

    $display("covered %0d draws, %0d zero-bound draws, %0d seed loads",
             n_draws, n_zero, n_seeds);
    $display("table regenerated %0d times, %0d mismatches", twist_count, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
